// ===== sv/ipc_pkg.sv =====
package ipc_pkg;

   // line buffer geometry
   localparam int MAX_WIDTH = 64;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int LEN_W     = $clog2(MAX_WIDTH + 1);

   // configuration register widths
   localparam int WIDTH_W  = 7;
   localparam int HEIGHT_W = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // one line buffer entry: pixel of the row above and pixel of this row
   typedef struct packed {
      logic up;
      logic mid;
   } entry_type;

   // per-item control toward the line buffer
   typedef struct packed {
      logic             accept;
      logic             row_end;
      logic             restart;
      logic             pixel;
      logic [COL_W-1:0] col;
   } line_ctl_type;

   // neighbor bits of the previous rows at the current and the next column
   typedef struct packed {
      logic mid_cur;
      logic up_cur;
      logic mid_next;
   } nbr_type;

endpackage

// ===== sv/ipc_req_if.sv =====
interface ipc_req_if;
   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/ipc_rsp_if.sv =====
interface ipc_rsp_if;
   logic valid;
   logic ready;
   logic all_connected;

   modport source (output valid, output all_connected, input ready);
   modport sink   (input valid, input all_connected, output ready);
endinterface

// ===== sv/ipc_line_buf.sv =====
module ipc_line_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  ipc_pkg::line_ctl_type ctl,
   output ipc_pkg::nbr_type      nbr
);

   // column store: one entry per column, rewritten as each row passes
   ipc_pkg::entry_type mem [ipc_pkg::MAX_WIDTH];

   // window on the stored rows: entry at the current column and the next one
   ipc_pkg::entry_type cur_ff;
   ipc_pkg::entry_type nxt_ff;

   // lengths of the two previous rows; entries past them read as clear
   logic [ipc_pkg::LEN_W-1:0] len1_ff, len1_in;
   logic [ipc_pkg::LEN_W-1:0] len2_ff, len2_in;

   logic [ipc_pkg::LEN_W-1:0] col_ext;
   logic [ipc_pkg::LEN_W-1:0] col_plus1;
   logic [ipc_pkg::COL_W-1:0] ahead_addr;
   logic                      in_len1;
   logic                      in_len2;
   ipc_pkg::entry_type        wr_entry;

   // mask stale entries by the previous row lengths
   always_comb begin
      col_ext   = ipc_pkg::LEN_W'(ctl.col);
      col_plus1 = col_ext + ipc_pkg::LEN_W'(1);
      in_len1   = col_ext < len1_ff;
      in_len2   = col_ext < len2_ff;
      nbr.mid_cur  = in_len1 & cur_ff.mid;
      nbr.up_cur   = in_len1 ? cur_ff.up : (in_len2 & cur_ff.mid);
      nbr.mid_next = (col_plus1 < len1_ff) & nxt_ff.mid;
      wr_entry.up  = nbr.mid_cur;
      wr_entry.mid = ctl.pixel;
      ahead_addr   = ctl.col + ipc_pkg::COL_W'(2);
   end

   // track row lengths, cleared at frame restart
   always_comb begin
      len1_in = len1_ff;
      len2_in = len2_ff;
      if (ctl.accept && ctl.row_end) begin
         if (ctl.restart) begin
            len1_in = '0;
            len2_in = '0;
         end else begin
            len1_in = col_plus1;
            len2_in = len1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff <= '0;
         len2_ff <= '0;
      end else begin
         len1_ff <= len1_in;
         len2_ff <= len2_in;
      end
   end

   // write the current column and prefetch two columns ahead, or columns 0 and 1 at row end
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         mem[ctl.col] <= wr_entry;
         if (ctl.row_end) begin
            // restart the window at column zero, bypassing this cycle's write
            cur_ff <= (ctl.col == ipc_pkg::COL_W'(0)) ? wr_entry : mem[0];
            nxt_ff <= (ctl.col == ipc_pkg::COL_W'(1)) ? wr_entry : mem[1];
         end else begin
            cur_ff <= nxt_ff;
            nxt_ff <= mem[ahead_addr];
         end
      end
   end

endmodule

// ===== sv/isolated_pixel_check.sv =====
// Isolated pixel check, 4-neighbour. Pixels of a binary image enter one item
// per clock in raster order; the frame size comes from image_width (low 7 bits kept,
// 1..64, zero reads as 1, larger values as 64) and image_height (zero reads as 1).
// On the frame's last pixel one verdict item leaves, all_connected = 1 when no
// painted pixel lacks a painted up, down, left or right neighbour, and the
// block restarts for the next frame. The verdict appears on rsp the cycle
// after the last pixel is taken. The input takes one item every cycle; the
// only stall is a frame's last pixel arriving while the previous verdict is
// still held in the output register. Previous rows live in a 64 x 2-bit
// column store with one write and up to two registered reads per cycle, read
// two columns ahead so the window is ready when the next pixel arrives. No
// clearing pass is needed after reset or between frames: row lengths mask
// entries that the current frame has not written.
module isolated_pixel_check (
   input  logic                           clock,
   input  logic                           reset,
   ipc_req_if.sink                        req,
   ipc_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [ipc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipc_pkg::CSR_W-1:0]      csr_wdata
);

   logic [ipc_pkg::WIDTH_W-1:0]  width_ff;
   logic [ipc_pkg::HEIGHT_W-1:0] height_ff;

   logic [ipc_pkg::COL_W-1:0]    col_ff, col_in;
   logic [ipc_pkg::HEIGHT_W-1:0] row_ff, row_in;
   logic                         ok_ff, ok_in;
   logic                         p1_ff, p2_ff, mp_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_data_ff;

   logic [ipc_pkg::LEN_W-1:0]    w_eff;
   logic [ipc_pkg::HEIGHT_W-1:0] h_eff;
   logic                         accept;
   logic                         row_end;
   logic                         last_row;
   logic                         frame_end;
   logic                         col_ge1, col_ge2;
   logic                         fail_up, fail_left, fail_self;

   ipc_pkg::line_ctl_type        ctl;
   ipc_pkg::nbr_type             nbr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ipc_pkg::WIDTH_W'(1);
         height_ff <= ipc_pkg::HEIGHT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            ipc_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[ipc_pkg::WIDTH_W-1:0];
            ipc_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata[ipc_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame size and locate the current pixel
   always_comb begin
      if (width_ff == '0)
         w_eff = ipc_pkg::LEN_W'(1);
      else if (width_ff > ipc_pkg::WIDTH_W'(ipc_pkg::MAX_WIDTH))
         w_eff = ipc_pkg::LEN_W'(ipc_pkg::MAX_WIDTH);
      else
         w_eff = ipc_pkg::LEN_W'(width_ff);
      h_eff     = (height_ff == '0) ? ipc_pkg::HEIGHT_W'(1) : height_ff;
      row_end   = (ipc_pkg::LEN_W'(col_ff) + ipc_pkg::LEN_W'(1)) >= w_eff;
      last_row  = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
      frame_end = row_end & last_row;
      col_ge1   = col_ff != '0;
      col_ge2   = col_ff[ipc_pkg::COL_W-1:1] != '0;
   end

   // hold only a frame's last pixel while the verdict register is blocked
   assign req.ready = ~(rsp_valid_ff & ~rsp.ready & frame_end);
   assign accept    = req.valid & req.ready;

   always_comb begin
      ctl.accept  = accept;
      ctl.row_end = row_end;
      ctl.restart = frame_end;
      ctl.pixel   = req.pixel;
      ctl.col     = col_ff;
   end

   ipc_line_buf u_line_buf (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .nbr   (nbr)
   );

   // judge the pixel above, the left pixel of the last row and the final pixel
   always_comb begin
      fail_up   = nbr.mid_cur & ~(nbr.up_cur | req.pixel | (col_ge1 & mp_ff)
                                  | (~row_end & nbr.mid_next));
      fail_left = last_row & col_ge1 & p1_ff & ~(mp_ff | req.pixel | (col_ge2 & p2_ff));
      fail_self = frame_end & req.pixel & ~(nbr.mid_cur | (col_ge1 & p1_ff));
      ok_in     = ok_ff & ~(fail_up | fail_left | fail_self);
   end

   // advance position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ipc_pkg::HEIGHT_W'(1);
         end else begin
            col_in = col_ff + ipc_pkg::COL_W'(1);
         end
      end
   end

   // verdict register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready)
         rsp_valid_in = 1'b0;
      if (accept && frame_end)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         ok_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept)
            ok_ff <= frame_end ? 1'b1 : ok_in;
      end
   end

   // pixel history (current row at the two previous columns, row above at the previous one) and verdict data
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_ff <= req.pixel;
         p2_ff <= p1_ff;
         mp_ff <= nbr.mid_cur;
         if (frame_end)
            rsp_data_ff <= ok_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.all_connected = rsp_data_ff;

   // a frame's last pixel always yields a verdict in the next cycle
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> rsp.valid)
      else $error("verdict missing after last pixel");

   // the input stalls only behind a blocked verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("input stalled without a blocked verdict");

   // the frame state restarts after each verdict
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> col_ff == '0 && row_ff == '0 && ok_ff)
      else $error("frame state not restarted");

endmodule
